// ===== rtl/spi_eeprom_page_write_sequencer_macros.svh =====
// Assertion helpers for the sequencer
`ifndef SPI_EEPROM_PAGE_WRITE_SEQUENCER_MACROS_SVH
`define SPI_EEPROM_PAGE_WRITE_SEQUENCER_MACROS_SVH

`ifndef SYNTH
`define SPIEE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spiee check failed");
`define SPIEE_NEVER(lbl, clk, rst_n, expr) \
    `SPIEE_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define SPIEE_ASSERT(lbl, clk, rst_n, prop)
`define SPIEE_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== rtl/spiee_pkg.sv =====
`default_nettype none

package spiee_pkg;

    localparam int DEF_PAGE_BYTES   = 16;
    localparam int DEF_ADDRESS_BITS = 16;
    localparam int JQ_DEPTH         = 4;

    typedef enum logic [2:0] {
        MODE_WRITE  = 3'd0,
        MODE_READ   = 3'd1,
        MODE_STATUS = 3'd2,
        MODE_WREN   = 3'd3,
        MODE_WRDI   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ACT_SEL_LOW  = 2'd0,
        ACT_SHIFT    = 2'd1,
        ACT_SEL_HIGH = 2'd2,
        ACT_REFUSE   = 2'd3
    } t_action;

    localparam logic [7:0] OP_READ    = 8'h03;
    localparam logic [7:0] OP_WRITE   = 8'h02;
    localparam logic [7:0] OP_WRDI    = 8'h04;
    localparam logic [7:0] OP_WREN    = 8'h06;
    localparam logic [7:0] OP_RDSR    = 8'h05;
    localparam logic [7:0] DUMMY_BYTE = 8'h00;
    localparam int         WIP_BIT    = 0;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] start_address;
        logic [7:0]  write_byte;
        logic        first_byte;
        logic        last_byte;
        logic [7:0]  status_reply;
    } t_req;

    typedef struct packed {
        t_action     action;
        logic [7:0]  tx_byte;
        logic        capture_reply;
        logic        status_expected;
        logic        end_of_run;
    } t_res;

    // one bit per output slot, emitted lowest first
    typedef enum logic [3:0] {
        SL_REFUSE = 4'd0,
        SL_CLOSE  = 4'd1,
        SL_SEL    = 4'd2,
        SL_CMD    = 4'd3,
        SL_AHI    = 4'd4,
        SL_ALO    = 4'd5,
        SL_DATA   = 4'd6,
        SL_END    = 4'd7,
        SL_PSEL   = 4'd8,
        SL_PCMD   = 4'd9,
        SL_PDUM   = 4'd10,
        SL_PEND   = 4'd11
    } t_slot;

    localparam int N_SLOTS = 12;

    typedef logic [N_SLOTS-1:0] t_slot_mask;

    typedef struct packed {
        t_slot_mask  mask;
        logic [7:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        cap;
    } t_job;

endpackage

`default_nettype wire

// ===== rtl/spiee_front.sv =====
`default_nettype none

module spiee_front import spiee_pkg::*; #(
    parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_req i_req,
    input  wire logic i_jq_full,
    output logic      o_full,
    output logic      o_job_push,
    output t_job      o_job
);

    localparam int CA_W   = (ADDRESS_BITS >= 16) ? 16 : ADDRESS_BITS;
    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int REM_W  = OFF_W + 1;
    localparam int RSH    = 24;
    localparam int PROD_W = CA_W + RSH;
    localparam int QP_W   = CA_W + 9;
    localparam int RECIP  = (1 << RSH) / PAGE_BYTES;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WRITE,
        PH_READ,
        PH_WAIT_START,
        PH_WAIT_PAGE
    } t_phase;

    typedef enum logic [1:0] {
        MOD_IDLE,
        MOD_MUL,
        MOD_FIX
    } t_mod;

    t_phase            r_phase, n_phase;
    t_mod              r_mod, n_mod;
    logic [CA_W-1:0]   r_addr, n_addr;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [7:0]        r_held_byte, n_held_byte;
    logic              r_held_last, n_held_last;
    logic [PROD_W-1:0] r_prod;

    logic              accept;
    logic              waiting;
    logic              close_run;
    logic [CA_W-1:0]   inc_addr;
    logic [OFF_W-1:0]  inc_off;
    logic [CA_W-1:0]   q_est;
    logic [QP_W-1:0]   qp;
    logic [QP_W-1:0]   rem_wide;
    logic [REM_W-1:0]  rem;
    logic [REM_W-1:0]  rem_fix;
    logic              do_send;
    logic [7:0]        send_byte;
    logic              send_last;

    assign o_full     = i_jq_full || (r_mod != MOD_IDLE);
    assign accept     = i_push && !o_full;
    assign o_job_push = accept;

    assign waiting   = (r_phase == PH_WAIT_START) || (r_phase == PH_WAIT_PAGE);
    assign close_run = (r_phase == PH_WRITE) || (r_phase == PH_READ);

    assign inc_addr = r_addr + 1'b1;
    assign inc_off  = (inc_addr == '0 || r_off == OFF_W'(PAGE_BYTES - 1)) ? '0
                                                                          : r_off + 1'b1;

    // page offset of a new start address: reciprocal multiply, then one fix-up
    assign q_est    = r_prod[PROD_W-1:RSH];
    assign qp       = QP_W'(q_est) * QP_W'(PAGE_BYTES);
    assign rem_wide = QP_W'(r_addr) - qp;
    assign rem      = rem_wide[REM_W-1:0];
    assign rem_fix  = (rem >= REM_W'(PAGE_BYTES)) ? rem - REM_W'(PAGE_BYTES) : rem;

    always_comb begin
        n_phase     = r_phase;
        n_mod       = r_mod;
        n_addr      = r_addr;
        n_off       = r_off;
        n_held_byte = r_held_byte;
        n_held_last = r_held_last;
        o_job       = '0;
        o_job.addr  = 16'(r_addr);
        do_send     = 1'b0;
        send_byte   = r_held_byte;
        send_last   = r_held_last;

        unique case (r_mod)
            MOD_MUL: begin
                n_mod = MOD_FIX;
            end
            MOD_FIX: begin
                n_mod = MOD_IDLE;
                n_off = rem_fix[OFF_W-1:0];
            end
            default: begin
                n_mod = r_mod;
            end
        endcase

        if (accept) begin
            if (i_req.mode > MODE_WRDI || ((i_req.mode == MODE_STATUS) != waiting)) begin
                o_job.mask[SL_REFUSE] = 1'b1;
            end else begin
                unique case (i_req.mode)
                    MODE_WRITE: begin
                        if (r_phase == PH_WRITE && !i_req.first_byte) begin
                            do_send   = 1'b1;
                            send_byte = i_req.write_byte;
                            send_last = i_req.last_byte;
                        end else begin
                            o_job.mask[SL_CLOSE] = close_run;
                            o_job.mask[SL_PSEL]  = 1'b1;
                            o_job.mask[SL_PCMD]  = 1'b1;
                            o_job.mask[SL_PDUM]  = 1'b1;
                            o_job.mask[SL_PEND]  = 1'b1;
                            n_addr      = i_req.start_address[CA_W-1:0];
                            n_held_byte = i_req.write_byte;
                            n_held_last = i_req.last_byte;
                            n_phase     = PH_WAIT_START;
                            n_mod       = MOD_MUL;
                        end
                    end
                    MODE_READ: begin
                        if (r_phase == PH_READ && !i_req.first_byte) begin
                            n_addr = inc_addr;
                        end else begin
                            o_job.mask[SL_CLOSE] = close_run;
                            o_job.mask[SL_SEL]   = 1'b1;
                            o_job.mask[SL_CMD]   = 1'b1;
                            o_job.mask[SL_AHI]   = 1'b1;
                            o_job.mask[SL_ALO]   = 1'b1;
                            o_job.cmd            = OP_READ;
                            o_job.addr           = 16'(i_req.start_address[CA_W-1:0]);
                            n_addr               = i_req.start_address[CA_W-1:0];
                        end
                        o_job.mask[SL_DATA] = 1'b1;
                        o_job.data          = DUMMY_BYTE;
                        o_job.cap           = 1'b1;
                        o_job.mask[SL_END]  = i_req.last_byte;
                        n_phase             = i_req.last_byte ? PH_IDLE : PH_READ;
                    end
                    MODE_STATUS: begin
                        if (i_req.status_reply[WIP_BIT]) begin
                            o_job.mask[SL_PSEL] = 1'b1;
                            o_job.mask[SL_PCMD] = 1'b1;
                            o_job.mask[SL_PDUM] = 1'b1;
                            o_job.mask[SL_PEND] = 1'b1;
                        end else begin
                            o_job.mask[SL_SEL] = 1'b1;
                            o_job.mask[SL_CMD] = 1'b1;
                            o_job.mask[SL_AHI] = 1'b1;
                            o_job.mask[SL_ALO] = 1'b1;
                            o_job.cmd          = OP_WRITE;
                            if (r_phase == PH_WAIT_START) begin
                                do_send = 1'b1;
                            end else begin
                                n_phase = PH_WRITE;
                            end
                        end
                    end
                    MODE_WREN, MODE_WRDI: begin
                        o_job.mask[SL_CLOSE] = close_run;
                        o_job.mask[SL_SEL]   = 1'b1;
                        o_job.mask[SL_CMD]   = 1'b1;
                        o_job.mask[SL_END]   = 1'b1;
                        o_job.cmd            = (i_req.mode == MODE_WREN) ? OP_WREN : OP_WRDI;
                        n_phase              = PH_IDLE;
                    end
                    default: begin
                        o_job.mask[SL_REFUSE] = 1'b1;
                    end
                endcase
            end

            if (do_send) begin
                o_job.mask[SL_DATA] = 1'b1;
                o_job.data          = send_byte;
                n_addr              = inc_addr;
                n_off               = inc_off;
                if (send_last) begin
                    o_job.mask[SL_END] = 1'b1;
                    n_phase            = PH_IDLE;
                end else if (inc_off == '0) begin
                    o_job.mask[SL_END]  = 1'b1;
                    o_job.mask[SL_PSEL] = 1'b1;
                    o_job.mask[SL_PCMD] = 1'b1;
                    o_job.mask[SL_PDUM] = 1'b1;
                    o_job.mask[SL_PEND] = 1'b1;
                    n_phase             = PH_WAIT_PAGE;
                end else begin
                    n_phase = PH_WRITE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_mod       <= MOD_IDLE;
            r_addr      <= '0;
            r_off       <= '0;
            r_held_byte <= '0;
            r_held_last <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_mod       <= n_mod;
            r_addr      <= n_addr;
            r_off       <= n_off;
            r_held_byte <= n_held_byte;
            r_held_last <= n_held_last;
        end
        if (r_mod == MOD_MUL) begin
            r_prod <= PROD_W'(r_addr) * PROD_W'(RECIP);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spiee_queue.sv =====
`default_nettype none

module spiee_queue import spiee_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    localparam int PTR_W = $clog2(JQ_DEPTH);

    t_job             r_mem [JQ_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [PTR_W:0]   r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (PTR_W + 1)'(JQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(JQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(JQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spiee_back.sv =====
`default_nettype none

module spiee_back import spiee_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_job_pop,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_res      o_res
);

    logic       r_busy;
    t_job       r_job;
    logic       r_out_valid;
    t_res       r_out;

    t_slot      idx;
    t_slot_mask rest;
    t_res       res;
    logic       adv;

    assign adv       = !r_out_valid || i_pop;
    assign o_empty   = !r_out_valid;
    assign o_res     = r_out;
    assign o_job_pop = !r_busy && i_job_valid;
    assign rest      = r_job.mask & (r_job.mask - 1'b1);

    always_comb begin
        idx = SL_REFUSE;
        for (int i = N_SLOTS - 1; i >= 0; i--) begin
            if (r_job.mask[i]) begin
                idx = t_slot'(4'(i));
            end
        end
    end

    always_comb begin
        res            = '0;
        res.end_of_run = (rest == '0);
        unique case (idx)
            SL_REFUSE: res.action = ACT_REFUSE;
            SL_CLOSE, SL_END, SL_PEND: res.action = ACT_SEL_HIGH;
            SL_SEL, SL_PSEL: res.action = ACT_SEL_LOW;
            SL_CMD: begin
                res.action  = ACT_SHIFT;
                res.tx_byte = r_job.cmd;
            end
            SL_AHI: begin
                res.action  = ACT_SHIFT;
                res.tx_byte = r_job.addr[15:8];
            end
            SL_ALO: begin
                res.action  = ACT_SHIFT;
                res.tx_byte = r_job.addr[7:0];
            end
            SL_DATA: begin
                res.action        = ACT_SHIFT;
                res.tx_byte       = r_job.data;
                res.capture_reply = r_job.cap;
            end
            SL_PCMD: begin
                res.action  = ACT_SHIFT;
                res.tx_byte = OP_RDSR;
            end
            SL_PDUM: begin
                res.action          = ACT_SHIFT;
                res.tx_byte         = DUMMY_BYTE;
                res.status_expected = 1'b1;
            end
            default: res.action = ACT_REFUSE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_busy && adv) begin
                r_out_valid <= 1'b1;
                r_job.mask  <= rest;
                if (rest == '0) begin
                    r_busy <= 1'b0;
                end
            end else if (adv) begin
                r_out_valid <= 1'b0;
            end
            if (o_job_pop) begin
                r_busy <= 1'b1;
                r_job  <= i_job;
            end
        end
        if (r_busy && adv) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spi_eeprom_page_write_sequencer.sv =====
// Channel   Direction  Handshake            Payload
// request   in         push / full          i_req (t_req)
// action    out        pop / empty          o_res (t_res)
//
// Each request becomes one job of 1 to 10 SPI actions; the back end loads the job
// into a register, then issues one action per cycle unless the output stalls.
// The front takes one request per cycle unless the job queue is full or the page
// offset multiply of a new write run is running; a 4-entry job queue sits between.
// Reset (synchronous, active low) returns the sequencer to idle with no run open.
// A stalled output holds the action register; the front keeps taking requests
// until the job queue fills.
`default_nettype none
`include "spi_eeprom_page_write_sequencer_macros.svh"

module spi_eeprom_page_write_sequencer import spiee_pkg::*; #(
    parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    output logic      full,
    input  wire t_req i_req,
    output logic      empty,
    input  wire logic pop,
    output t_res      o_res
);

    logic job_push;
    t_job job_in;
    logic jq_full;
    logic jq_empty;
    logic job_pop;
    t_job job_out;

    spiee_front #(
        .PAGE_BYTES   (PAGE_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_req      (i_req),
        .i_jq_full  (jq_full),
        .o_full     (full),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    spiee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (jq_full),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_empty (jq_empty)
    );

    spiee_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!jq_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (o_res)
    );

    `SPIEE_NEVER(a_jq_no_overflow, i_clk, i_rst_n, job_push && jq_full)
    `SPIEE_ASSERT(a_refuse_alone, i_clk, i_rst_n, (!empty && o_res.action == ACT_REFUSE) |-> o_res.end_of_run)
    `SPIEE_ASSERT(a_status_on_dummy, i_clk, i_rst_n, (!empty && o_res.status_expected) |-> (o_res.action == ACT_SHIFT && o_res.tx_byte == DUMMY_BYTE))
    `SPIEE_NEVER(a_capture_only_shift, i_clk, i_rst_n, !empty && o_res.capture_reply && o_res.action != ACT_SHIFT)

endmodule

`default_nettype wire

// ===== tb/sv/spi_eeprom_page_write_sequencer_test.sv =====
`timescale 1ns / 1ps

module spi_eeprom_page_write_sequencer_test;
    import spiee_pkg::*;

    localparam int          HALF_PERIOD    = 6;
    localparam int          RESET_CYCLES   = 12;
    localparam int          RANDOM_ITEMS   = 130;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          TAIL_CYCLES    = 40;
    localparam int          REPORT_LIMIT   = 10;
    localparam logic [2:0]  MODE_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]  MODE_UNUSED_LAST  = 3'd7;
    localparam logic [15:0] ADDR_MASK = (DEF_ADDRESS_BITS >= 16) ? 16'hFFFF :
                                        16'((1 << DEF_ADDRESS_BITS) - 1);

    typedef enum logic [2:0] {
        RUN_IDLE       = 3'd0,
        RUN_WRITE      = 3'd1,
        RUN_READ       = 3'd2,
        RUN_WAIT_START = 3'd3,
        RUN_WAIT_PAGE  = 3'd4
    } t_run_phase;

    class eeprom_seq_scoreboard;
        t_res       expected_q[$];
        t_run_phase phase;
        logic [15:0] cur_addr;
        logic [7:0]  held_byte;
        logic        held_last;
        int          mismatches;
        int          checked;

        function new();
            phase      = RUN_IDLE;
            cur_addr   = '0;
            held_byte  = '0;
            held_last  = 1'b0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit awaiting_status();
            return phase == RUN_WAIT_START || phase == RUN_WAIT_PAGE;
        endfunction

        function void emit(t_action act, logic [7:0] tx, logic cap, logic st);
            t_res r;
            r.action          = act;
            r.tx_byte         = tx;
            r.capture_reply   = cap;
            r.status_expected = st;
            r.end_of_run      = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void emit_poll();
            emit(ACT_SEL_LOW, 8'h00, 1'b0, 1'b0);
            emit(ACT_SHIFT, OP_RDSR, 1'b0, 1'b0);
            emit(ACT_SHIFT, DUMMY_BYTE, 1'b0, 1'b1);
            emit(ACT_SEL_HIGH, 8'h00, 1'b0, 1'b0);
        endfunction

        function void emit_cmd_addr(logic [7:0] op);
            emit(ACT_SHIFT, op, 1'b0, 1'b0);
            emit(ACT_SHIFT, cur_addr[15:8], 1'b0, 1'b0);
            emit(ACT_SHIFT, cur_addr[7:0], 1'b0, 1'b0);
        endfunction

        function void close_run();
            if (phase == RUN_WRITE || phase == RUN_READ)
                emit(ACT_SEL_HIGH, 8'h00, 1'b0, 1'b0);
            phase = RUN_IDLE;
        endfunction

        function void put_write_data(logic [7:0] b, logic last);
            emit(ACT_SHIFT, b, 1'b0, 1'b0);
            cur_addr = (cur_addr + 16'd1) & ADDR_MASK;
            if (last) begin
                emit(ACT_SEL_HIGH, 8'h00, 1'b0, 1'b0);
                phase = RUN_IDLE;
            end else if ((cur_addr % DEF_PAGE_BYTES) == 0) begin
                emit(ACT_SEL_HIGH, 8'h00, 1'b0, 1'b0);
                emit_poll();
                phase = RUN_WAIT_PAGE;
            end else begin
                phase = RUN_WRITE;
            end
        endfunction

        // predicts the transfers caused by one accepted request
        function void note_request(t_req rq);
            t_res tail;
            if (rq.mode > MODE_WRDI || ((rq.mode == MODE_STATUS) != awaiting_status())) begin
                emit(ACT_REFUSE, 8'h00, 1'b0, 1'b0);
            end else begin
                case (rq.mode)
                    MODE_WRITE: begin
                        if (phase == RUN_WRITE && !rq.first_byte) begin
                            put_write_data(rq.write_byte, rq.last_byte);
                        end else begin
                            close_run();
                            cur_addr  = rq.start_address & ADDR_MASK;
                            held_byte = rq.write_byte;
                            held_last = rq.last_byte;
                            emit_poll();
                            phase = RUN_WAIT_START;
                        end
                    end
                    MODE_READ: begin
                        if (phase == RUN_READ && !rq.first_byte) begin
                            cur_addr = (cur_addr + 16'd1) & ADDR_MASK;
                        end else begin
                            close_run();
                            cur_addr = rq.start_address & ADDR_MASK;
                            emit(ACT_SEL_LOW, 8'h00, 1'b0, 1'b0);
                            emit_cmd_addr(OP_READ);
                        end
                        emit(ACT_SHIFT, DUMMY_BYTE, 1'b1, 1'b0);
                        if (rq.last_byte) begin
                            emit(ACT_SEL_HIGH, 8'h00, 1'b0, 1'b0);
                            phase = RUN_IDLE;
                        end else begin
                            phase = RUN_READ;
                        end
                    end
                    MODE_STATUS: begin
                        if (rq.status_reply[WIP_BIT]) begin
                            emit_poll();
                        end else begin
                            emit(ACT_SEL_LOW, 8'h00, 1'b0, 1'b0);
                            emit_cmd_addr(OP_WRITE);
                            if (phase == RUN_WAIT_START) put_write_data(held_byte, held_last);
                            else phase = RUN_WRITE;
                        end
                    end
                    default: begin
                        close_run();
                        emit(ACT_SEL_LOW, 8'h00, 1'b0, 1'b0);
                        emit(ACT_SHIFT, (rq.mode == MODE_WREN) ? OP_WREN : OP_WRDI, 1'b0, 1'b0);
                        emit(ACT_SEL_HIGH, 8'h00, 1'b0, 1'b0);
                        phase = RUN_IDLE;
                    end
                endcase
            end
            tail = expected_q.pop_back();
            tail.end_of_run = 1'b1;
            expected_q.push_back(tail);
        endfunction

        function string fmt(t_res r);
            return $sformatf("act=%0d tx=%02h cap=%b st=%b end=%b", r.action, r.tx_byte,
                             r.capture_reply, r.status_expected, r.end_of_run);
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("transfer %0d: none expected, got %s", checked, fmt(got));
            end else begin
                want = expected_q.pop_front();
                if (got.action !== want.action || got.tx_byte !== want.tx_byte ||
                    got.capture_reply !== want.capture_reply ||
                    got.status_expected !== want.status_expected ||
                    got.end_of_run !== want.end_of_run) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("transfer %0d: exp %s, got %s", checked, fmt(want), fmt(got));
                end
            end
            checked++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    t_req i_req;
    logic empty;
    logic pop;
    t_res o_res;

    eeprom_seq_scoreboard sb;
    int  accepted;
    int  burst_left;
    bit  no_gaps;
    bit  hold_req;
    int  stall_count;

    spi_eeprom_page_write_sequencer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_result(o_res);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) stall_count <= 0;
        else stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG_LIMIT) begin
            $display("spi_eeprom_page_write_sequencer: mismatch");
            $finish;
        end
    end

    // receiver: pop pattern changes per segment, plus one long hold-off
    initial begin
        int seg_left;
        int style;
        int tick;
        pop <= 1'b0;
        seg_left = 0;
        style = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    style = $urandom_range(3);
                    seg_left = $urandom_range(80, 10);
                end
                seg_left--;
                tick++;
                case (style)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(1));
                    2: pop <= ($urandom_range(3) == 0);
                    default: pop <= (tick % 3 == 0);
                endcase
            end
        end
    end

    function automatic t_req rand_req();
        t_req r;
        r.mode          = 3'($urandom_range(MODE_WRDI));
        r.start_address = 16'($urandom);
        r.write_byte    = 8'($urandom);
        r.first_byte    = 1'($urandom_range(1));
        r.last_byte     = 1'($urandom_range(1));
        r.status_reply  = 8'($urandom);
        return r;
    endfunction

    function automatic t_req mk(logic [2:0] m, logic [15:0] a, logic [7:0] d, bit f, bit l);
        t_req r;
        r = rand_req();
        r.mode          = m;
        r.start_address = a;
        r.write_byte    = d;
        r.first_byte    = f;
        r.last_byte     = l;
        return r;
    endfunction

    function automatic t_req mk_status(logic [7:0] st);
        t_req r;
        r = rand_req();
        r.mode         = MODE_STATUS;
        r.status_reply = st;
        return r;
    endfunction

    task automatic pace();
        int gap;
        if (!no_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 20) :
                                                        $urandom_range(8);
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
                if (gap > 0) begin
                    push <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    task automatic send_req(t_req r);
        push  <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (full);
        sb.note_request(r);
        accepted++;
        pace();
    endtask

    // answers polls until the write can go on; now and then a refused item
    task automatic settle();
        t_req r;
        logic [7:0] st;
        while (sb.awaiting_status()) begin
            if ($urandom_range(15) == 0) begin
                r = rand_req();
                if (r.mode == MODE_STATUS) r.mode = MODE_WREN;
                send_req(r);
            end else begin
                st = 8'($urandom);
                st[WIP_BIT] = ($urandom_range(3) == 0);
                send_req(mk_status(st));
            end
        end
    endtask

    task automatic write_run(logic [15:0] addr, int len, bit finish);
        settle();
        for (int i = 0; i < len; i++) begin
            send_req(mk(MODE_WRITE, addr, 8'($urandom), i == 0, finish && i == len - 1));
            settle();
        end
    endtask

    task automatic read_run(logic [15:0] addr, int len, bit finish);
        settle();
        for (int i = 0; i < len; i++)
            send_req(mk(MODE_READ, addr, 8'($urandom), i == 0, finish && i == len - 1));
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] near_page_end();
        logic [15:0] a;
        a = 16'($urandom) | 16'(DEF_PAGE_BYTES - 1);
        return a - 16'($urandom_range(3));
    endfunction

    initial begin
        int base;
        int pick;
        bit pressure_done;
        sb = new();
        accepted = 0;
        burst_left = 0;
        no_gaps = 1'b0;
        hold_req = 1'b0;
        stall_count = 0;
        pressure_done = 1'b0;
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_req <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_req(mk(MODE_UNUSED_FIRST, 16'h1234, 8'h55, 1'b1, 1'b1));
        send_req(mk(MODE_UNUSED_LAST, 16'hFFFF, 8'hFF, 1'b0, 1'b0));
        send_req(mk_status(8'hFF));
        send_req(mk(MODE_WREN, 16'h0000, 8'h00, 1'b0, 1'b0));
        send_req(mk(MODE_WRITE, 16'hFFFE, 8'hFF, 1'b1, 1'b0));
        send_req(mk(MODE_WRITE, 16'h0000, 8'h00, 1'b0, 1'b0));
        send_req(mk(MODE_READ, 16'h0000, 8'h00, 1'b1, 1'b1));
        send_req(mk_status(8'hFF));
        send_req(mk_status(8'hFE));
        send_req(mk(MODE_WRITE, 16'h0000, 8'h00, 1'b0, 1'b0));
        send_req(mk(MODE_WREN, 16'h0000, 8'h00, 1'b0, 1'b0));
        send_req(mk_status(8'h00));
        send_req(mk(MODE_WRITE, 16'hFFFF, 8'hA5, 1'b0, 1'b1));
        send_req(mk(MODE_WRITE, 16'h002F, 8'h5A, 1'b1, 1'b1));
        send_req(mk_status(8'h00));
        send_req(mk(MODE_READ, 16'hFFFF, 8'h00, 1'b1, 1'b0));
        send_req(mk(MODE_READ, 16'h0000, 8'hFF, 1'b0, 1'b0));
        send_req(mk(MODE_READ, 16'h0000, 8'h00, 1'b0, 1'b1));
        send_req(mk(MODE_READ, 16'h8000, 8'h00, 1'b0, 1'b0));
        send_req(mk(MODE_WRITE, 16'h7FF0, 8'h81, 1'b0, 1'b0));
        send_req(mk_status(8'h02));
        send_req(mk(MODE_READ, 16'h00FF, 8'h00, 1'b1, 1'b0));
        send_req(mk(MODE_WRDI, 16'h0000, 8'h00, 1'b1, 1'b1));
        drain();

        // random
        base = accepted;
        while (accepted - base < RANDOM_ITEMS) begin
            if (!pressure_done && accepted - base >= 50) begin
                pressure_done = 1'b1;
                no_gaps = 1'b1;
                hold_req = 1'b1;
                write_run(near_page_end(), 16, 1'b1);
                read_run(16'($urandom), 6, 1'b1);
                no_gaps = 1'b0;
                drain();
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                write_run(($urandom_range(1) == 0) ? near_page_end() : 16'($urandom),
                          $urandom_range(20, 1), $urandom_range(7) != 0);
            end else if (pick < 70) begin
                read_run(16'($urandom), $urandom_range(6, 1), $urandom_range(7) != 0);
            end else if (pick < 80) begin
                send_req(mk(($urandom_range(1) == 0) ? MODE_WREN : MODE_WRDI,
                            16'($urandom), 8'($urandom), 1'($urandom), 1'($urandom)));
            end else if (pick < 95) begin
                send_req(mk(3'($urandom_range(MODE_UNUSED_LAST)), 16'($urandom), 8'($urandom),
                            1'($urandom), 1'($urandom)));
            end else begin
                drain();
            end
        end
        settle();
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("spi_eeprom_page_write_sequencer: match");
        end else begin
            $display("spi_eeprom_page_write_sequencer: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/spiee_pkg.sv
rtl/spiee_front.sv
rtl/spiee_queue.sv
rtl/spiee_back.sv
rtl/spi_eeprom_page_write_sequencer.sv
tb/sv/spi_eeprom_page_write_sequencer_test.sv
